// ===== rtl/slsp_pkg.sv =====
// ----------------------------------------------------------------------------
// slsp_pkg
// Shared types and constants for the sorted list slot pool.
// ----------------------------------------------------------------------------
package slsp_pkg;

  localparam int unsigned PoolDepth = 1024;
  localparam int unsigned SlotBits  = 10;
  localparam int unsigned LinkBits  = 11;
  localparam int unsigned ValueBits = 32;

  localparam logic [LinkBits-1:0] NullLink = LinkBits'(PoolDepth);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NOT_USED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_READ_SLOT,
    S_LINK,
    S_DONE
  } state_e;

  // One list entry as held in the node memory.
  typedef struct packed {
    logic                 used;
    logic [ValueBits-1:0] value;
    logic [LinkBits-1:0]  next;
    logic [LinkBits-1:0]  prev;
  } node_t;

  // Port bundle of the node memory.
  typedef struct packed {
    logic                rd_en;
    logic [SlotBits-1:0] rd_addr;
    logic                wr_en;
    logic [SlotBits-1:0] wr_addr;
    node_t               wr_data;
  } node_req_t;

endpackage

// ===== rtl/slsp_node_mem.sv =====
// ----------------------------------------------------------------------------
// slsp_node_mem
// Node memory: value and both links per slot, one read and one write port.
// ----------------------------------------------------------------------------
module slsp_node_mem (
  input  logic                clk_i,
  input  slsp_pkg::node_req_t req_i,
  output slsp_pkg::node_t     rd_data_o
);

  slsp_pkg::node_t mem [slsp_pkg::PoolDepth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem[req_i.rd_addr];
    end
  end

endmodule

// ===== rtl/slsp_free_fifo.sv =====
// ----------------------------------------------------------------------------
// slsp_free_fifo
// Queue of released slots, handed back oldest first. Read data is
// prefetched so the head entry is always at the output.
// ----------------------------------------------------------------------------
module slsp_free_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [slsp_pkg::SlotBits-1:0] push_slot_i,
  input  logic                          pop_i,
  output logic                          nonempty_o,
  output logic [slsp_pkg::SlotBits-1:0] head_slot_o
);

  logic [slsp_pkg::SlotBits-1:0] mem [slsp_pkg::PoolDepth];
  logic [slsp_pkg::SlotBits-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q;
  logic [slsp_pkg::LinkBits-1:0] count_q;
  logic [slsp_pkg::SlotBits-1:0] head_q;
  logic                          push_ok;

  // Queue never overflows: each slot is queued at most once
  assign push_ok    = push_i && (count_q < slsp_pkg::LinkBits'(slsp_pkg::PoolDepth));
  assign rd_ptr_d   = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
  assign nonempty_o = (count_q != '0);
  assign head_slot_o = head_q;

  // Write new entries
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[wr_ptr_q] <= push_slot_i;
    end
  end

  // Fetch head entry; pushes and pops never share a cycle
  always_ff @(posedge clk_i) begin
    if (push_ok && (count_q == '0)) begin
      head_q <= push_slot_i;
    end else begin
      head_q <= mem[rd_ptr_d];
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      if (push_ok) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
        count_q  <= count_q + 1'b1;
      end else if (pop_i) begin
        count_q  <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sorted_list_slot_pool_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_list_slot_pool_unit
// Sorted doubly linked list of signed values over a fixed slot pool.
// ----------------------------------------------------------------------------
// Sequence: find and insert walk the list from the head, with one node read
//   per entry walked; find ends on a match or at the tail, and insert then
//   writes the new node and patches its neighbours, also when appended.
// Remove reads the slot and patches both neighbours; read, a slot not in use and a full insert do no walk.
// Throughput: one transaction at a time; busy is high until the result.
// Reset: list empty, no slot in use, free queue empty; slots at or above the
//   fill count read as unused, so no clearing pass. The receiver cannot stall.
module sorted_list_slot_pool_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic signed [31:0] item_value_i,
  input  logic [9:0]  slot_number_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [9:0]  result_slot_o,
  output logic signed [31:0] result_value_o
);

  localparam int unsigned SB = slsp_pkg::SlotBits;
  localparam int unsigned LB = slsp_pkg::LinkBits;
  localparam int unsigned VB = slsp_pkg::ValueBits;

  slsp_pkg::state_e  state_q, state_d;
  slsp_pkg::opcode_e op_q;
  logic [VB-1:0]     key_q;
  logic [SB-1:0]     slot_q;
  logic [LB-1:0]     cur_q, cur_d;
  logic [LB-1:0]     head_q, head_d, tail_q, tail_d;
  logic [LB-1:0]     fresh_q, fresh_d;
  logic [SB-1:0]     new_q, new_d;
  logic [1:0]        link_step_q, link_step_d;
  logic [LB-1:0]     pl_q, pl_d, ql_q, ql_d;
  logic [1:0]        status_q, status_d;
  logic [SB-1:0]     rslot_q, rslot_d;
  logic [VB-1:0]     rval_q, rval_d;
  logic              done_q;
  logic              fifo_push, fifo_pop, fifo_nonempty;
  logic [SB-1:0]     fifo_head;
  slsp_pkg::node_req_t req;
  slsp_pkg::node_t     rd;
  logic              key_ge, key_eq;
  logic              slot_unused;

  slsp_node_mem u_node_mem (
    .clk_i     (clk_i),
    .req_i     (req),
    .rd_data_o (rd)
  );

  slsp_free_fifo u_free_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_slot_i (slot_q),
    .pop_i       (fifo_pop),
    .nonempty_o  (fifo_nonempty),
    .head_slot_o (fifo_head)
  );

  // Signed compare of stored value against the key
  assign key_ge = ($signed(rd.value) >= $signed(key_q));
  assign key_eq = (rd.value == key_q);

  // Slot never taken, or released since
  assign slot_unused = ({1'b0, slot_q} >= fresh_q) || !rd.used;

  assign busy           = (state_q != slsp_pkg::S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign result_slot_o  = rslot_q;
  assign result_value_o = rval_q;

  // Next state and memory requests
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fresh_d     = fresh_q;
    new_d       = new_q;
    link_step_d = link_step_q;
    pl_d        = pl_q;
    ql_d        = ql_q;
    status_d    = status_q;
    rslot_d     = '0;
    rval_d      = '0;
    fifo_push   = 1'b0;
    fifo_pop    = 1'b0;
    req         = '0;
    unique case (state_q)
      slsp_pkg::S_IDLE: begin
        if (start) begin
          cur_d = head_q;
          unique case (slsp_pkg::opcode_e'(opcode_i))
            slsp_pkg::OP_INSERT: begin
              if (fifo_nonempty) begin
                new_d    = fifo_head;
                fifo_pop = 1'b1;
                state_d  = slsp_pkg::S_WALK;
              end else if (fresh_q < LB'(slsp_pkg::PoolDepth)) begin
                new_d   = fresh_q[SB-1:0];
                fresh_d = fresh_q + 1'b1;
                state_d = slsp_pkg::S_WALK;
              end else begin
                status_d = slsp_pkg::ST_FULL;
                state_d  = slsp_pkg::S_DONE;
              end
            end
            slsp_pkg::OP_FIND: state_d = slsp_pkg::S_WALK;
            slsp_pkg::OP_REMOVE, slsp_pkg::OP_READ: begin
              req.rd_en   = 1'b1;
              req.rd_addr = slot_number_i;
              state_d     = slsp_pkg::S_READ_SLOT;
            end
            default: state_d = slsp_pkg::S_IDLE;
          endcase
          link_step_d = '0;
          // Issue the first walk read
          if (head_q != slsp_pkg::NullLink && opcode_i[1] == 1'b0) begin
            req.rd_en   = 1'b1;
            req.rd_addr = head_q[SB-1:0];
          end
        end
      end
      slsp_pkg::S_WALK: begin
        // link_step 0: waiting for the read of cur
        if (link_step_q == 2'd0 && cur_q != slsp_pkg::NullLink) begin
          link_step_d = 2'd1;
        end else begin
          link_step_d = '0;
          if (cur_q == slsp_pkg::NullLink) begin
            if (op_q == slsp_pkg::OP_FIND) begin
              status_d = slsp_pkg::ST_NOT_FOUND;
              state_d  = slsp_pkg::S_DONE;
            end else begin
              pl_d    = tail_q;
              state_d = slsp_pkg::S_LINK;
            end
          end else if (op_q == slsp_pkg::OP_FIND && key_eq) begin
            status_d = slsp_pkg::ST_OK;
            rslot_d  = cur_q[SB-1:0];
            state_d  = slsp_pkg::S_DONE;
          end else if (op_q == slsp_pkg::OP_INSERT && key_ge) begin
            pl_d    = rd.prev;
            state_d = slsp_pkg::S_LINK;
          end else begin
            cur_d = rd.next;
            if (rd.next != slsp_pkg::NullLink) begin
              req.rd_en   = 1'b1;
              req.rd_addr = rd.next[SB-1:0];
            end
            link_step_d = '0;
          end
        end
        // keep output slot while finishing a find
        if (state_d == slsp_pkg::S_DONE && op_q == slsp_pkg::OP_FIND && key_eq
            && cur_q != slsp_pkg::NullLink) begin
          rslot_d = cur_q[SB-1:0];
        end
      end
      slsp_pkg::S_LINK: begin
        // step 0: write new node, read prev; 1: fix prev's next, read cur; 2: fix cur's prev
        unique case (link_step_q)
          2'd0: begin
            req.wr_en         = 1'b1;
            req.wr_addr       = new_q;
            req.wr_data.used  = 1'b1;
            req.wr_data.value = key_q;
            req.wr_data.next  = cur_q;
            req.wr_data.prev  = pl_q;
            if (pl_q == slsp_pkg::NullLink) begin
              head_d = {1'b0, new_q};
            end else begin
              req.rd_en   = 1'b1;
              req.rd_addr = pl_q[SB-1:0];
            end
            if (cur_q == slsp_pkg::NullLink) begin
              tail_d = {1'b0, new_q};
            end
            link_step_d = 2'd1;
          end
          2'd1: begin
            if (pl_q != slsp_pkg::NullLink) begin
              req.wr_en        = 1'b1;
              req.wr_addr      = pl_q[SB-1:0];
              req.wr_data      = rd;
              req.wr_data.next = {1'b0, new_q};
            end
            if (cur_q != slsp_pkg::NullLink) begin
              req.rd_en   = 1'b1;
              req.rd_addr = cur_q[SB-1:0];
            end
            link_step_d = 2'd2;
          end
          2'd2: begin
            if (cur_q != slsp_pkg::NullLink) begin
              req.wr_en        = 1'b1;
              req.wr_addr      = cur_q[SB-1:0];
              req.wr_data      = rd;
              req.wr_data.prev = {1'b0, new_q};
            end
            status_d    = slsp_pkg::ST_OK;
            rslot_d     = new_q;
            link_step_d = '0;
            state_d     = slsp_pkg::S_DONE;
          end
          default: state_d = slsp_pkg::S_DONE;
        endcase
      end
      slsp_pkg::S_READ_SLOT: begin
        // step 0: slot data arrives; 1: patch prev; 2: patch next
        unique case (link_step_q)
          2'd0: begin
            if (slot_unused) begin
              status_d = slsp_pkg::ST_NOT_USED;
              state_d  = slsp_pkg::S_DONE;
            end else if (op_q == slsp_pkg::OP_READ) begin
              status_d = slsp_pkg::ST_OK;
              rval_d   = rd.value;
              state_d  = slsp_pkg::S_DONE;
            end else begin
              pl_d        = rd.prev;
              ql_d        = rd.next;
              req.wr_en   = 1'b1;
              req.wr_addr = slot_q;
              req.wr_data.used  = 1'b0;
              req.wr_data.value = rd.value;
              req.wr_data.next  = slsp_pkg::NullLink;
              req.wr_data.prev  = slsp_pkg::NullLink;
              fifo_push   = 1'b1;
              if (rd.prev == slsp_pkg::NullLink) begin
                head_d = rd.next;
              end else begin
                req.rd_en   = 1'b1;
                req.rd_addr = rd.prev[SB-1:0];
              end
              if (rd.next == slsp_pkg::NullLink) begin
                tail_d = rd.prev;
              end
              link_step_d = 2'd1;
            end
          end
          2'd1: begin
            if (pl_q != slsp_pkg::NullLink) begin
              req.wr_en        = 1'b1;
              req.wr_addr      = pl_q[SB-1:0];
              req.wr_data      = rd;
              req.wr_data.next = ql_q;
            end
            if (ql_q != slsp_pkg::NullLink) begin
              req.rd_en   = 1'b1;
              req.rd_addr = ql_q[SB-1:0];
            end
            link_step_d = 2'd2;
          end
          2'd2: begin
            if (ql_q != slsp_pkg::NullLink) begin
              req.wr_en        = 1'b1;
              req.wr_addr      = ql_q[SB-1:0];
              req.wr_data      = rd;
              req.wr_data.prev = pl_q;
            end
            status_d    = slsp_pkg::ST_OK;
            link_step_d = '0;
            state_d     = slsp_pkg::S_DONE;
          end
          default: state_d = slsp_pkg::S_DONE;
        endcase
      end
      slsp_pkg::S_DONE: begin
        rslot_d = rslot_q;
        rval_d  = rval_q;
        state_d = slsp_pkg::S_IDLE;
      end
      default: state_d = slsp_pkg::S_IDLE;
    endcase
  end

  // Capture the transaction
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q   <= slsp_pkg::opcode_e'(opcode_i);
      key_q  <= item_value_i;
      slot_q <= slot_number_i;
    end
    new_q    <= new_d;
    pl_q     <= pl_d;
    ql_q     <= ql_d;
    cur_q    <= cur_d;
    status_q <= status_d;
    rslot_q  <= rslot_d;
    rval_q   <= rval_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slsp_pkg::S_IDLE;
      head_q      <= slsp_pkg::NullLink;
      tail_q      <= slsp_pkg::NullLink;
      fresh_q     <= '0;
      link_step_q <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fresh_q     <= fresh_d;
      link_step_q <= link_step_d;
      done_q      <= (state_d == slsp_pkg::S_DONE);
    end
  end

endmodule
